>>> sv/mlfq_pkg.sv
// ============================================================================
// mlfq_pkg
// Shared widths, codes and controller/datapath interface types for the
// three-level feedback queue scheduler.
// ============================================================================
`default_nettype none

package mlfq_pkg;

    localparam int LEVELS    = 3;
    localparam int TASK_W    = 4;
    localparam int LVL_W     = 2;
    localparam int QNT_W     = 8;
    localparam int SVC_IN_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // input function codes
    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L2 = 2'd2;

    // queue levels
    localparam logic [LVL_W-1:0] LVL0 = 2'd0;
    localparam logic [LVL_W-1:0] LVL1 = 2'd1;
    localparam logic [LVL_W-1:0] LVL2 = 2'd2;

    // quantum reset values
    localparam logic [QNT_W-1:0] QUANTUM_L0_RST = 8'd4;
    localparam logic [QNT_W-1:0] QUANTUM_L1_RST = 8'd8;
    localparam logic [QNT_W-1:0] QUANTUM_L2_RST = 8'd12;

    typedef struct packed {
        logic arrive;   // apply the arrival on the input ports
        logic charge;   // charge one tick to the running task
        logic pop;      // start the head of the highest non-empty level
        logic load;     // capture the result registers
    } t_dp_cmd;

    typedef struct packed {
        logic running_valid;
        logic any_queued;
    } t_dp_status;

endpackage

`default_nettype wire

>>> sv/mlfq_ctrl.sv
// ============================================================================
// mlfq_ctrl
// Sequencing state machine: accepts transactions, steps a tick through
// charge, select and load, and holds the result until it is taken.
// ============================================================================
`default_nettype none

module mlfq_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_func,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    input  wire mlfq_pkg::t_dp_status i_status,
    output mlfq_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHARGE,
        S_SELECT,
        S_LOAD,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   in_take;

    assign in_take = i_in_valid && !r_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take && (i_func == mlfq_pkg::FUNC_TICK)) begin
                    n_state = S_CHARGE;
                end
            end
            S_CHARGE: n_state = S_SELECT;
            S_SELECT: n_state = S_LOAD;
            S_LOAD:   n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= (n_state != S_IDLE);
            r_out_valid <= (n_state == S_OUT);
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.arrive = (r_state == S_IDLE) && in_take && (i_func == mlfq_pkg::FUNC_ARRIVAL);
        o_cmd.charge = (r_state == S_CHARGE);
        o_cmd.pop    = (r_state == S_SELECT) && !i_status.running_valid
                       && i_status.any_queued;
        o_cmd.load   = (r_state == S_LOAD);
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> sv/mlfq_datapath.sv
// ============================================================================
// mlfq_datapath
// Level queues, service store, running-task registers, quantum registers
// and result registers of the scheduler.
// ============================================================================
`default_nettype none

module mlfq_datapath #(
    parameter int MAX_TASKS    = 16,
    parameter int SERVICE_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire mlfq_pkg::t_dp_cmd              i_cmd,
    output mlfq_pkg::t_dp_status                o_status,
    input  wire  [mlfq_pkg::TASK_W-1:0]         i_task_id,
    input  wire  [mlfq_pkg::SVC_IN_W-1:0]       i_service_time,
    input  wire                                 i_cfg_we,
    input  wire  [mlfq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [mlfq_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_finished_valid,
    output logic [mlfq_pkg::TASK_W-1:0]         o_finished_task,
    output logic                                o_demoted_valid,
    output logic [mlfq_pkg::TASK_W-1:0]         o_demoted_task,
    output logic [mlfq_pkg::LVL_W-1:0]          o_demoted_level,
    output logic                                o_run_valid,
    output logic [mlfq_pkg::TASK_W-1:0]         o_run_task,
    output logic [mlfq_pkg::LVL_W-1:0]          o_run_level,
    output logic [mlfq_pkg::QNT_W-1:0]          o_quantum_left
);

    localparam int LEVELS = mlfq_pkg::LEVELS;
    localparam int TW     = mlfq_pkg::TASK_W;
    localparam int LW     = mlfq_pkg::LVL_W;
    localparam int QW     = mlfq_pkg::QNT_W;
    localparam int SW     = SERVICE_BITS;
    localparam int IW     = $clog2(MAX_TASKS);
    localparam int PW     = $clog2(MAX_TASKS);
    localparam int CW     = $clog2(MAX_TASKS + 1);
    localparam int QDEPTH = LEVELS * MAX_TASKS;
    localparam int AW     = $clog2(QDEPTH);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);
    localparam logic [PW-1:0] PTR_LAST = PW'(MAX_TASKS - 1);

    // storage
    logic [TW-1:0] r_qmem   [QDEPTH];
    logic [SW-1:0] r_svcmem [MAX_TASKS];
    logic [SW-1:0] r_svc_rd;
    logic [TW-1:0] r_q_rd;

    logic [QW-1:0] r_qreg  [LEVELS];
    logic [PW-1:0] r_head  [LEVELS];
    logic [PW-1:0] r_tail  [LEVELS];
    logic [CW-1:0] r_count [LEVELS];

    logic          r_run_valid;
    logic [TW-1:0] r_run_task;
    logic [LW-1:0] r_run_level;
    logic [QW-1:0] r_quantum;
    logic          r_popped;
    logic          r_fin_v;
    logic [TW-1:0] r_fin_t;
    logic          r_dem_v;
    logic [TW-1:0] r_dem_t;
    logic [LW-1:0] r_dem_l;

    // decoded signals
    logic [31:0]   svc_in_w, id_w, run_w, wa_w, ra_w;
    logic [SW-1:0] svc_in;
    logic [IW-1:0] arr_idx, run_idx;
    logic          arr_ok;
    logic [SW-1:0] svc_dec;
    logic [QW-1:0] q_dec;
    logic [LW-1:0] tgt;
    logic [LW-1:0] sel_lv;
    logic          push_en;
    logic [LW-1:0] push_lv;
    logic [TW-1:0] push_id;
    logic          svc_we;
    logic [IW-1:0] svc_waddr;
    logic [SW-1:0] svc_wdata;
    logic [AW-1:0] q_waddr, q_raddr;
    logic [QW-1:0] q_sel, q_load;
    logic [TW-1:0] run_task_n;
    logic          charge_run;
    logic          run_done;

    assign svc_in_w = 32'(i_service_time);
    assign svc_in   = svc_in_w[SW-1:0];
    assign id_w     = 32'(i_task_id);
    assign arr_idx  = id_w[IW-1:0];
    assign run_w    = 32'(r_run_task);
    assign run_idx  = run_w[IW-1:0];
    assign arr_ok   = (svc_in != '0) && (id_w < 32'(MAX_TASKS))
                      && (r_count[0] < CNT_MAX);

    assign svc_dec    = (r_svc_rd != '0) ? r_svc_rd - SW'(1) : '0;
    assign q_dec      = (r_quantum != '0) ? r_quantum - QW'(1) : '0;
    assign tgt        = (r_run_level < mlfq_pkg::LVL2) ? r_run_level + LW'(1)
                                                      : mlfq_pkg::LVL2;
    assign charge_run = i_cmd.charge && r_run_valid;
    // finished, or quantum spent: the slot empties either way
    assign run_done   = (svc_dec == '0) || (q_dec == '0);

    always_comb begin
        if (r_count[0] != '0) begin
            sel_lv = mlfq_pkg::LVL0;
        end else if (r_count[1] != '0) begin
            sel_lv = mlfq_pkg::LVL1;
        end else begin
            sel_lv = mlfq_pkg::LVL2;
        end
    end

    assign o_status.running_valid = r_run_valid;
    assign o_status.any_queued    = (r_count[0] != '0) || (r_count[1] != '0)
                                    || (r_count[2] != '0);

    // push: arrival to level 0, or demotion to the target level if it has room
    always_comb begin
        push_en = 1'b0;
        push_lv = mlfq_pkg::LVL0;
        push_id = i_task_id;
        if (i_cmd.arrive) begin
            push_en = arr_ok;
        end else if (charge_run) begin
            push_lv = tgt;
            push_id = r_run_task;
            push_en = (svc_dec != '0) && (q_dec == '0) && (r_count[tgt] < CNT_MAX);
        end
    end

    always_comb begin
        svc_we    = (i_cmd.arrive && arr_ok) || charge_run;
        svc_waddr = i_cmd.charge ? run_idx : arr_idx;
        svc_wdata = i_cmd.charge ? svc_dec : svc_in;
    end

    assign wa_w    = 32'(push_lv) * MAX_TASKS + 32'(r_tail[push_lv]);
    assign q_waddr = wa_w[AW-1:0];
    assign ra_w    = 32'(sel_lv) * MAX_TASKS + 32'(r_head[sel_lv]);
    assign q_raddr = ra_w[AW-1:0];

    assign q_sel  = r_qreg[sel_lv];
    assign q_load = (q_sel != '0) ? q_sel : QW'(1);

    assign run_task_n = r_popped ? r_q_rd : r_run_task;

    // memories
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_qmem[q_waddr] <= push_id;
        end
        r_q_rd <= r_qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (svc_we) begin
            r_svcmem[svc_waddr] <= svc_wdata;
        end
        r_svc_rd <= r_svcmem[run_idx];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qreg[0]   <= mlfq_pkg::QUANTUM_L0_RST;
            r_qreg[1]   <= mlfq_pkg::QUANTUM_L1_RST;
            r_qreg[2]   <= mlfq_pkg::QUANTUM_L2_RST;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_run_level <= '0;
            r_quantum   <= '0;
            r_popped    <= 1'b0;
            r_fin_v     <= 1'b0;
            r_fin_t     <= '0;
            r_dem_v     <= 1'b0;
            r_dem_t     <= '0;
            r_dem_l     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mlfq_pkg::CFG_QUANTUM_L0: r_qreg[0] <= i_cfg_data;
                    mlfq_pkg::CFG_QUANTUM_L1: r_qreg[1] <= i_cfg_data;
                    mlfq_pkg::CFG_QUANTUM_L2: r_qreg[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            for (int l = 0; l < LEVELS; l++) begin
                if (push_en && (push_lv == LW'(l))) begin
                    r_tail[l]  <= (r_tail[l] == PTR_LAST) ? '0 : r_tail[l] + PW'(1);
                    r_count[l] <= r_count[l] + CW'(1);
                end
                if (i_cmd.pop && (sel_lv == LW'(l))) begin
                    r_head[l]  <= (r_head[l] == PTR_LAST) ? '0 : r_head[l] + PW'(1);
                    r_count[l] <= r_count[l] - CW'(1);
                end
            end

            if (i_cmd.charge) begin
                r_fin_v <= r_run_valid && (svc_dec == '0);
                r_fin_t <= r_run_task;
                r_dem_v <= r_run_valid && (svc_dec != '0) && (q_dec == '0);
                r_dem_t <= r_run_task;
                r_dem_l <= tgt;
                if (r_run_valid) begin
                    r_quantum <= q_dec;
                    if (run_done) begin
                        r_run_valid <= 1'b0;
                    end
                end
            end

            r_popped <= i_cmd.pop;
            if (i_cmd.pop) begin
                r_run_valid <= 1'b1;
                r_run_level <= sel_lv;
                r_quantum   <= q_load;
            end

            // popped id arrives from the registered queue memory read in the cycle after the pop
            if (i_cmd.load) begin
                r_run_task <= run_task_n;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_finished_valid <= r_fin_v;
            o_finished_task  <= r_fin_v ? r_fin_t : '0;
            o_demoted_valid  <= r_dem_v;
            o_demoted_task   <= r_dem_v ? r_dem_t : '0;
            o_demoted_level  <= r_dem_v ? r_dem_l : '0;
            o_run_valid      <= r_run_valid;
            o_run_task       <= r_run_valid ? run_task_n : '0;
            o_run_level      <= r_run_valid ? r_run_level : '0;
            o_quantum_left   <= r_run_valid ? r_quantum : '0;
        end
    end

endmodule

`default_nettype wire

>>> sv/mlfq_three_level_scheduler.sv
// ============================================================================
// mlfq_three_level_scheduler
// Three-level feedback queue scheduler, non-preemptive between levels.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per
//   arrival (i_func = 0) or tick (i_func = 1). An arrival is absorbed in the
//   cycle it is accepted and produces no result; the next transaction may
//   follow in the next cycle.
//   A tick passes through charge, select and load steps (paced by the
//   registered reads of the service store and the queue memory), and its
//   result appears on o_out_valid after the load step. The input stalls
//   from acceptance until the cycle after the result is taken, so a new
//   tick is accepted only after the last result is taken, and any output
//   stall holds it off further.
//   Output channel (o_out_valid / i_out_stall): the result is held stable
//   while i_out_stall is high.
//   Configuration: i_cfg_we writes i_cfg_data to quantum register i_cfg_idx
//   in the same cycle; indexes beyond the list are ignored. Write only when
//   no tick is in flight.
//   Reset (synchronous, active low) empties all queues, clears the running
//   slot and restores quanta 4, 8 and 12. No clearing pass is needed.
// ============================================================================
`default_nettype none

module mlfq_three_level_scheduler #(
    parameter int MAX_TASKS    = 16,
    parameter int SERVICE_BITS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_func,
    input  wire  [mlfq_pkg::TASK_W-1:0]     i_task_id,
    input  wire  [mlfq_pkg::SVC_IN_W-1:0]   i_service_time,
    input  wire                             i_cfg_we,
    input  wire  [mlfq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [mlfq_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic                            o_finished_valid,
    output logic [mlfq_pkg::TASK_W-1:0]     o_finished_task,
    output logic                            o_demoted_valid,
    output logic [mlfq_pkg::TASK_W-1:0]     o_demoted_task,
    output logic [mlfq_pkg::LVL_W-1:0]      o_demoted_level,
    output logic                            o_run_valid,
    output logic [mlfq_pkg::TASK_W-1:0]     o_run_task,
    output logic [mlfq_pkg::LVL_W-1:0]      o_run_level,
    output logic [mlfq_pkg::QNT_W-1:0]      o_quantum_left
);

    mlfq_pkg::t_dp_cmd    cmd;
    mlfq_pkg::t_dp_status status;

    mlfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mlfq_datapath #(
        .MAX_TASKS    (MAX_TASKS),
        .SERVICE_BITS (SERVICE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_task_id        (i_task_id),
        .i_service_time   (i_service_time),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_finished_valid (o_finished_valid),
        .o_finished_task  (o_finished_task),
        .o_demoted_valid  (o_demoted_valid),
        .o_demoted_task   (o_demoted_task),
        .o_demoted_level  (o_demoted_level),
        .o_run_valid      (o_run_valid),
        .o_run_task       (o_run_task),
        .o_run_level      (o_run_level),
        .o_quantum_left   (o_quantum_left)
    );

    // a pending result always blocks the input side
    a_stall_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    // an accepted tick yields its result after the three internal steps
    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_func == mlfq_pkg::FUNC_TICK))
        |-> ##4 o_out_valid)
        else $error("tick result not presented on time");

    // a task cannot both finish and be demoted in one tick
    a_fin_dem_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_finished_valid && o_demoted_valid))
        else $error("finish and demotion reported together");

    // an idle slot reports no quantum
    a_idle_no_quantum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_run_valid) |-> (o_quantum_left == '0))
        else $error("quantum reported with no task running");

endmodule

`default_nettype wire
